### rtl/core/slc_pkg.sv
// Shared types, constants and the helper function of the source line classifier.
`default_nettype none

package slc_pkg;

  // Size of the lookahead window and of the delimiters it is matched against.
  localparam int MAX_DELIM         = 4;
  localparam int NUM_STRING_DELIMS = 2;
  localparam int COUNT_WIDTH       = 32;

  // Longest delimiter that a register can describe after clamping.
  localparam int DLEN_MAX = (MAX_DELIM < 4) ? MAX_DELIM : 4;
  // Positions judged for one item: the window plus the new byte.
  localparam int EXT_LEN  = MAX_DELIM + 1;
  // Judged positions padded with zero bytes so every delimiter compare has data.
  localparam int PAD_LEN  = EXT_LEN + DLEN_MAX - 1;
  localparam int FILL_W   = $clog2(MAX_DELIM + 1);
  localparam int N_W      = $clog2(MAX_DELIM + 2);
  // Visible character count saturates above the longest delimiter length.
  localparam int VIS_W    = 3;
  // Per-item counter increment: one bump per judged byte plus the final line.
  localparam int INC_W    = $clog2(EXT_LEN + 2);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 35;

  // Character codes.
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Line counter slots.
  localparam int CNT_TOTAL   = 0;
  localparam int CNT_EMPTY   = 1;
  localparam int CNT_COMMENT = 2;
  localparam int CNT_CODE    = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LANG_EN   = 3'd0,
    REG_LINE_CMT  = 3'd1,
    REG_BLK_BEGIN = 3'd2,
    REG_BLK_END   = 3'd3,
    REG_STR_A     = 3'd4,
    REG_STR_B     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_BLOCK  = 2'd3
  } mode_e;

  // One delimiter register: length on top, bytes first-in-low below.
  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] bytes;
  } delim_t;

  typedef struct packed {
    logic   lang_en;
    delim_t line_cmt;
    delim_t blk_begin;
    delim_t blk_end;
    delim_t str_a;
    delim_t str_b;
  } cfg_t;

  // Delimiter hits at one judged position.
  typedef struct packed {
    logic str_hit;
    logic blk_begin_hit;
    logic line_cmt_hit;
    logic blk_end_hit;
  } match_t;

  typedef match_t [EXT_LEN-1:0]     match_vec_t;
  typedef logic [PAD_LEN-1:0][7:0]  ext_buf_t;

  // Per-line parser state.
  typedef struct packed {
    mode_e            mode;
    logic [VIS_W-1:0] vis;
    logic             blk_countable;
    logic             blk_ended;
    logic             line_cmt_counts;
  } line_st_t;

  localparam line_st_t ST_RESET = '{
    mode:            MODE_NORMAL,
    vis:             '0,
    blk_countable:   1'b1,
    blk_ended:       1'b0,
    line_cmt_counts: 1'b0
  };

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       end_of_text;
  } slc_in_t;

  typedef struct packed {
    logic [31:0] total_lines;
    logic [31:0] empty_lines;
    logic [31:0] comment_lines;
    logic [31:0] code_lines;
  } slc_out_t;

  // Delimiter length clamped to what the window can hold.
  function automatic logic [2:0] slc_delim_len(delim_t d);
    logic [2:0] n;
    n = d.len;
    if (n > 3'(DLEN_MAX)) begin
      n = 3'(DLEN_MAX);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/core/slc_cfg_regs.sv
// Configuration register file of the source line classifier.
`default_nettype none

module slc_cfg_regs import slc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LANG_EN:   cfg.lang_en   <= cfg_data[0];
        REG_LINE_CMT:  cfg.line_cmt  <= cfg_data;
        REG_BLK_BEGIN: cfg.blk_begin <= cfg_data;
        REG_BLK_END:   cfg.blk_end   <= cfg_data;
        REG_STR_A:     cfg.str_a     <= cfg_data;
        REG_STR_B:     cfg.str_b     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/slc_delim_match.sv
// Parallel delimiter compares at every judged position of the lookahead buffer.
`default_nettype none

module slc_delim_match import slc_pkg::*; (
  input  wire cfg_t     cfg,
  input  wire ext_buf_t ext,
  output match_vec_t    hits
);

  // A delimiter matches when it is present and each of its bytes agrees.
  function automatic logic match_at(delim_t d, logic [DLEN_MAX-1:0][7:0] win);
    logic [2:0] n;
    logic       ok;
    n  = slc_delim_len(d);
    ok = (n != 3'd0);
    for (int i = 0; i < DLEN_MAX; i++) begin
      if (3'(i) < n && win[i] != d.bytes[8*i +: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // One set of compares per position; bytes past the text are zero.
  for (genvar p = 0; p < EXT_LEN; p++) begin : g_pos
    logic [DLEN_MAX-1:0][7:0] win;
    assign win = ext[p +: DLEN_MAX];
    assign hits[p].str_hit       = match_at(cfg.str_a, win) ||
                                   (NUM_STRING_DELIMS > 1 && match_at(cfg.str_b, win));
    assign hits[p].blk_begin_hit = match_at(cfg.blk_begin, win);
    assign hits[p].line_cmt_hit  = match_at(cfg.line_cmt, win);
    assign hits[p].blk_end_hit   = match_at(cfg.blk_end, win);
  end

endmodule

`default_nettype wire

### rtl/core/slc_line_engine.sv
// Lookahead window, parser state and line counters, updated once per item.
`default_nettype none

module slc_line_engine import slc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       item_go,
  input  wire slc_in_t    item,
  output ext_buf_t        ext,
  input  wire match_vec_t hits,
  output logic            res_valid,
  output slc_out_t        res
);

  typedef struct packed {
    line_st_t   st;
    logic [3:0] bump;
  } step_t;

  logic [MAX_DELIM-1:0][7:0] window;
  logic [FILL_W-1:0]         fill;
  line_st_t                  st;
  logic [COUNT_WIDTH-1:0]    cnt [4];

  logic [N_W-1:0]            n_bytes;
  logic                      full;
  logic [EXT_LEN-1:0]        jen;
  line_st_t                  chain_st [EXT_LEN+1];
  logic [3:0]                bumps [EXT_LEN+1];
  step_t                     step_res [EXT_LEN];
  step_t                     fin;
  logic [INC_W-1:0]          inc [4];
  logic [COUNT_WIDTH:0]      sum [4];
  logic [COUNT_WIDTH-1:0]    cnt_next [4];
  logic [MAX_DELIM-1:0][7:0] window_next;
  logic [FILL_W-1:0]         fill_next;
  logic [2:0]                end_len;

  assign end_len = slc_delim_len(cfg.blk_end);

  // Close a line: decide comment or code and reset the per-line flags.
  function automatic step_t end_line_fn(step_t s, logic en, logic [2:0] len_end);
    step_t r;
    logic  cmt_line;
    logic  as_code;
    logic  normal_like;
    r           = s;
    cmt_line    = (s.st.mode == MODE_LINE && s.st.line_cmt_counts) ||
                  (s.st.mode == MODE_BLOCK && s.st.blk_countable) || s.st.blk_ended;
    as_code     = 1'b1;
    normal_like = (s.st.mode == MODE_NORMAL || s.st.mode == MODE_STRING);
    if (en) begin
      if (cmt_line) begin
        as_code = s.st.blk_ended ? (s.st.vis != len_end) : 1'b0;
      end
      if (cmt_line && !as_code) begin
        r.bump[CNT_COMMENT] = 1'b1;
      end
      if ((s.st.mode == MODE_LINE && !s.st.line_cmt_counts) ||
          (s.st.mode == MODE_BLOCK && as_code) ||
          (normal_like && s.st.vis != '0 && as_code)) begin
        r.bump[CNT_CODE] = 1'b1;
      end
      if (s.st.mode == MODE_LINE) begin
        r.st.mode = MODE_NORMAL;
      end
      r.st.line_cmt_counts = 1'b0;
      r.st.blk_countable   = 1'b1;
      r.st.blk_ended       = 1'b0;
    end
    return r;
  endfunction

  // Judge one byte at a judged position in the current mode.
  function automatic step_t judge_fn(line_st_t s, logic [7:0] c, match_t m, logic en,
                                     logic [2:0] len_end);
    step_t r;
    r.st   = s;
    r.bump = '0;
    if (c != CH_CR) begin
      if (c == CH_LF) begin
        r.bump[CNT_TOTAL] = 1'b1;
        r.bump[CNT_EMPTY] = (s.vis == '0);
        r = end_line_fn(r, en, len_end);
        r.st.vis = '0;
      end else begin
        if (en) begin
          case (s.mode)
            MODE_NORMAL: begin
              if (m.str_hit) begin
                r.st.mode = MODE_STRING;
              end else if (m.blk_begin_hit) begin
                r.st.blk_countable = (s.vis == '0);
                r.st.mode          = MODE_BLOCK;
              end else if (m.line_cmt_hit) begin
                r.st.mode            = MODE_LINE;
                r.st.line_cmt_counts = (s.vis == '0);
              end
            end
            MODE_STRING: begin
              if (m.str_hit) begin
                r.st.mode = MODE_NORMAL;
              end
            end
            MODE_BLOCK: begin
              if (m.blk_end_hit) begin
                r.st.mode      = MODE_NORMAL;
                r.st.blk_ended = 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (c != CH_SP && c != CH_TAB && s.vis != '1) begin
          r.st.vis = s.vis + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Window plus the incoming byte, zero padded past the text.
  always_comb begin
    for (int i = 0; i < MAX_DELIM; i++) begin
      ext[i] = window[i];
    end
    for (int i = MAX_DELIM; i < PAD_LEN; i++) begin
      ext[i] = CH_NUL;
    end
    for (int i = 0; i < EXT_LEN; i++) begin
      if (item.has_byte && fill == FILL_W'(i)) begin
        ext[i] = item.char_byte;
      end
    end
  end

  assign n_bytes = N_W'(fill) + N_W'(item.has_byte);
  assign full    = (n_bytes == N_W'(EXT_LEN));

  // Positions judged: the head when the window overflows, all bytes at end of text.
  always_comb begin
    for (int p = 0; p < EXT_LEN; p++) begin
      if (item.end_of_text) begin
        jen[p] = item_go && (N_W'(p) < n_bytes);
      end else begin
        jen[p] = item_go && (p == 0) && full;
      end
    end
  end

  // Judge chain over the positions, then the final line at end of text.
  always_comb begin
    chain_st[0] = st;
    for (int p = 0; p < EXT_LEN; p++) begin
      step_res[p]   = judge_fn(chain_st[p], ext[p], hits[p], cfg.lang_en, end_len);
      chain_st[p+1] = jen[p] ? step_res[p].st : chain_st[p];
      bumps[p]      = jen[p] ? step_res[p].bump : 4'b0000;
    end
    fin.st                = chain_st[EXT_LEN];
    fin.bump              = '0;
    fin.bump[CNT_TOTAL]   = 1'b1;
    fin                   = end_line_fn(fin, cfg.lang_en, end_len);
    fin.bump[CNT_EMPTY]   = (fin.st.vis == '0);
    bumps[EXT_LEN]        = (item_go && item.end_of_text) ? fin.bump : 4'b0000;
  end

  // Saturating counter update.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      inc[k] = '0;
      for (int p = 0; p <= EXT_LEN; p++) begin
        inc[k] = inc[k] + INC_W'(bumps[p][k]);
      end
      sum[k]      = {1'b0, cnt[k]} + (COUNT_WIDTH+1)'(inc[k]);
      cnt_next[k] = sum[k][COUNT_WIDTH] ? '1 : sum[k][COUNT_WIDTH-1:0];
    end
  end

  // Window after the item: drop the judged head when it overflowed.
  always_comb begin
    for (int i = 0; i < MAX_DELIM; i++) begin
      window_next[i] = full ? ext[i+1] : ext[i];
    end
    fill_next = full ? FILL_W'(MAX_DELIM) : n_bytes[FILL_W-1:0];
  end

  assign res_valid         = item_go && item.end_of_text;
  assign res.total_lines   = 32'(cnt_next[CNT_TOTAL]);
  assign res.empty_lines   = 32'(cnt_next[CNT_EMPTY]);
  assign res.comment_lines = 32'(cnt_next[CNT_COMMENT]);
  assign res.code_lines    = 32'(cnt_next[CNT_CODE]);

  // State registers; end of text returns everything to its reset value.
  always_ff @(posedge clk) begin
    if (rst || (item_go && item.end_of_text)) begin
      window <= '0;
      fill   <= '0;
      st     <= ST_RESET;
      for (int k = 0; k < 4; k++) begin
        cnt[k] <= '0;
      end
    end else if (item_go) begin
      window <= window_next;
      fill   <= fill_next;
      st     <= chain_st[EXT_LEN];
      for (int k = 0; k < 4; k++) begin
        cnt[k] <= cnt_next[k];
      end
    end
  end

  // The state is clean after a text ends.
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    item_go && item.end_of_text |=> fill == '0 && st.mode == MODE_NORMAL)
    else $error("state not cleared after end of text");

  // A byte that fits in the window grows the fill by one.
  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    item_go && !item.end_of_text && item.has_byte && fill != FILL_W'(MAX_DELIM)
    |=> fill == $past(fill) + 1'b1)
    else $error("window fill did not advance");

  // Empty lines are always a subset of all lines.
  a_empty_le_total: assert property (@(posedge clk) disable iff (rst)
    cnt[CNT_EMPTY] <= cnt[CNT_TOTAL])
    else $error("empty line count exceeds total");

endmodule

`default_nettype wire

### rtl/core/source_line_classifier.sv
// Top level of the source line classifier: input register, engine and result register.
// Throughput: one byte transaction per clock cycle, unless an end-of-text item waits behind an untaken result.
// The counts pass from the engine into the result register once the end-of-text item leaves the input register.
// An end-of-text item waits in the input register while a previous result is untaken.
// Reset (rst, synchronous): window, parser state and counters clear; registers read zero.
`default_nettype none

module source_line_classifier import slc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire slc_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output slc_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       pipe_v;
  slc_in_t    pipe;
  logic       go;
  ext_buf_t   ext;
  match_vec_t hits;
  logic       res_valid;
  slc_out_t   res;

  slc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item moves on unless it ends a text and the result register is busy.
  assign go       = pipe_v && (!pipe.end_of_text || !out_valid || out_ready);
  assign in_ready = !pipe_v || go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= 1'b0;
    end else if (in_ready) begin
      pipe_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pipe <= in_data;
    end
  end

  slc_line_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_go   (go),
    .item      (pipe),
    .ext       (ext),
    .hits      (hits),
    .res_valid (res_valid),
    .res       (res)
  );

  slc_delim_match u_match (
    .cfg  (cfg),
    .ext  (ext),
    .hits (hits)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

  // Input stalls only behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> pipe_v && pipe.end_of_text && out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // A finished text always reaches the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> out_valid)
    else $error("result transaction lost");

endmodule

`default_nettype wire
